@@ src/bwts_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bwts_pkg
// Shared widths and defaults of the bilinear wrap texture sampler.
// ----------------------------------------------------------------------------
package bwts_pkg;
  localparam int MaxSideDefault  = 256;
  localparam int CoordFracDefault = 8;
  localparam int CoordW  = 24;   // sample_x / sample_y
  localparam int SizeRegW = 9;   // image_width / image_height
  localparam int PixelW  = 32;
  localparam int ChanW   = 8;
  localparam int NumChan = 4;
  localparam int InDataW = 96;
  localparam int CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_HEIGHT = 1'b1;

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;
endpackage

`default_nettype wire

@@ src/bwts_wrap.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bwts_wrap
// Wraps one coordinate modulo the image size, one quotient bit per cycle,
// and gives near texel, far texel and fractional weight.
// ----------------------------------------------------------------------------
module bwts_wrap
  import bwts_pkg::*;
#(
  parameter int MAX_SIDE        = MaxSideDefault,
  parameter int COORD_FRAC_BITS = CoordFracDefault
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  input  wire logic [CoordW-1:0]                  coord,
  input  wire logic [$clog2(MAX_SIDE+1)-1:0]      size,
  output logic                                    busy,
  output logic [$clog2(MAX_SIDE+1)-1:0]           n0,
  output logic [$clog2(MAX_SIDE+1)-1:0]           n1,
  output logic [COORD_FRAC_BITS-1:0]              frac
);
  localparam int ZW = $clog2(MAX_SIDE+1);
  localparam int IW = CoordW - COORD_FRAC_BITS;
  localparam int CW = $clog2(IW+1);

  logic [IW-1:0]              mag;
  logic [ZW-1:0]              rem;
  logic                       neg;
  logic [COORD_FRAC_BITS-1:0] f0;
  logic [CW-1:0]              cnt;

  logic [ZW:0]   trial;
  logic [ZW-1:0] rem_next;
  logic [ZW-1:0] r;

  always_comb begin
    trial = {rem, mag[IW-1]};
    if (trial >= {1'b0, size}) rem_next = ZW'(trial - {1'b0, size});
    else rem_next = trial[ZW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(IW);
      neg  <= coord[CoordW-1];
      // floor mod of a negative value via the one's complement
      mag  <= coord[CoordW-1] ? ~coord[CoordW-1:COORD_FRAC_BITS]
                              : coord[CoordW-1:COORD_FRAC_BITS];
      f0   <= coord[COORD_FRAC_BITS-1:0];
      rem  <= '0;
    end else if (busy) begin
      rem <= rem_next;
      mag <= {mag[IW-2:0], 1'b0};
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) busy <= 1'b0;
    end
  end

  always_comb begin
    r = neg ? ZW'(size - ZW'(1) - rem) : rem;
    if (f0[COORD_FRAC_BITS-1]) n0 = r;
    else if (r != '0) n0 = r - ZW'(1);
    else n0 = size - ZW'(1);
    n1   = (n0 < size - ZW'(1)) ? n0 + ZW'(1) : '0;
    frac = {~f0[COORD_FRAC_BITS-1], f0[COORD_FRAC_BITS-2:0]};
  end
endmodule

`default_nettype wire

@@ src/bwts_blend.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bwts_blend
// Two-stage bilinear blend of four packed texels, all channels in parallel.
// ----------------------------------------------------------------------------
module bwts_blend
  import bwts_pkg::*;
#(
  parameter int COORD_FRAC_BITS = CoordFracDefault
) (
  input  wire logic                         clk,
  input  wire logic                         en_vert,
  input  wire logic                         en_horz,
  input  wire logic [PixelW-1:0]            c00,
  input  wire logic [PixelW-1:0]            c01,
  input  wire logic [PixelW-1:0]            c10,
  input  wire logic [PixelW-1:0]            c11,
  input  wire logic [COORD_FRAC_BITS-1:0]   fx,
  input  wire logic [COORD_FRAC_BITS-1:0]   fy,
  output logic [PixelW-1:0]                 pixel
);
  localparam int WW = COORD_FRAC_BITS + 1;
  localparam int PW = ChanW + WW + 1;
  localparam int SW = PW + WW + 1;

  logic [WW-1:0] gx, gy, fxw, fyw, fx_r;
  logic [WW-1:0] gx_r;
  logic [PW-1:0] p0 [NumChan];
  logic [PW-1:0] p1 [NumChan];
  logic [SW-1:0] s  [NumChan];
  logic [SW-1:0] v  [NumChan];

  assign fxw = {1'b0, fx};
  assign fyw = {1'b0, fy};
  assign gx  = WW'(1 << COORD_FRAC_BITS) - fxw;
  assign gy  = WW'(1 << COORD_FRAC_BITS) - fyw;

  always_ff @(posedge clk) begin
    if (en_vert) begin
      gx_r <= gx;
      fx_r <= fxw;
      for (int ch = 0; ch < NumChan; ch++) begin
        p0[ch] <= PW'(c00[ch*ChanW +: ChanW]) * PW'(gy) +
                  PW'(c01[ch*ChanW +: ChanW]) * PW'(fyw);
        p1[ch] <= PW'(c10[ch*ChanW +: ChanW]) * PW'(gy) +
                  PW'(c11[ch*ChanW +: ChanW]) * PW'(fyw);
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < NumChan; ch++) begin
      s[ch] = SW'(p0[ch]) * SW'(gx_r) + SW'(p1[ch]) * SW'(fx_r);
      v[ch] = s[ch] >> (2 * COORD_FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (en_horz) begin
      for (int ch = 0; ch < NumChan; ch++) begin
        pixel[ch*ChanW +: ChanW] <= (v[ch] > SW'(255)) ? 8'hFF : v[ch][ChanW-1:0];
      end
    end
  end
endmodule

`default_nettype wire

@@ src/bilinear_wrap_texture_sampler_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bilinear_wrap_texture_sampler_core
// Pixel store with write and bilinear repeat-wrap sample requests.
// ----------------------------------------------------------------------------
// Write: the store is written at the transfer, next item accepted in the following cycle.
// Sample: 24 - COORD_FRAC_BITS wrap iterations (one quotient bit a cycle), leaving
// S_WRAP, four reads from the store, 2 blend stages and the output register;
// the next item is accepted once the result is registered, later while the
// previous result waits with m_tready low.
// Reset clears control state and size registers (both 1); the store is not
// cleared and needs no clearing pass.
module bilinear_wrap_texture_sampler_core
  import bwts_pkg::*;
#(
  parameter int MAX_SIDE        = MaxSideDefault,
  parameter int COORD_FRAC_BITS = CoordFracDefault
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  // write_col, write_row, write_pixel, sample_x, sample_y
  input  wire logic [InDataW-1:0]   s_tdata,
  // req_type
  input  wire logic                 s_tuser,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  // sampled_pixel
  output logic [PixelW-1:0]         m_tdata,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CfgIdxW-1:0]   cfg_index,
  input  wire logic [SizeRegW-1:0]  cfg_data
);
  localparam int ZW    = $clog2(MAX_SIDE+1);
  localparam int AW    = $clog2(MAX_SIDE*MAX_SIDE);
  localparam int Depth = MAX_SIDE * MAX_SIDE;

  typedef enum logic [2:0] {S_IDLE, S_WRAP, S_FETCH, S_VERT, S_HORZ, S_OUT} state_t;

  state_t              state;
  logic [SizeRegW-1:0] image_width, image_height;
  logic [ZW-1:0]       w_eff, h_eff;
  logic [PixelW-1:0]   pixel_store [Depth];
  logic [PixelW-1:0]   rd_data;
  logic [AW-1:0]       rd_addr;
  logic [2:0]          rd_idx;
  logic [PixelW-1:0]   tex [4];

  logic [7:0]          write_col, write_row;
  logic [PixelW-1:0]   write_pixel;
  logic [CoordW-1:0]   sample_x, sample_y;
  logic                in_xfer, wr_en;
  logic                busy_x, busy_y;
  logic [ZW-1:0]       x0, x1, y0, y1;
  logic [COORD_FRAC_BITS-1:0] fx, fy;
  logic [PixelW-1:0]   blend_pixel;
  logic                en_vert, en_horz;

  assign write_col   = s_tdata[7:0];
  assign write_row   = s_tdata[15:8];
  assign write_pixel = s_tdata[47:16];
  assign sample_x    = s_tdata[71:48];
  assign sample_y    = s_tdata[95:72];

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign in_xfer   = s_tvalid && s_tready;

  function automatic logic [ZW-1:0] clamp_size(input logic [SizeRegW-1:0] v);
    if (v == '0) return ZW'(1);
    if (32'(v) > 32'(MAX_SIDE)) return ZW'(MAX_SIDE);
    return ZW'(v);
  endfunction

  assign w_eff = clamp_size(image_width);
  assign h_eff = clamp_size(image_height);

  assign wr_en = in_xfer && (s_tuser == REQ_WRITE) &&
                 (32'(write_col) < 32'(w_eff)) && (32'(write_row) < 32'(h_eff));

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= SizeRegW'(1);
      image_height <= SizeRegW'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WIDTH:  image_width  <= cfg_data;
        REG_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  bwts_wrap #(.MAX_SIDE(MAX_SIDE), .COORD_FRAC_BITS(COORD_FRAC_BITS)) u_wrap_x (
    .clk(clk), .rst(rst), .start(in_xfer && (s_tuser == REQ_SAMPLE)),
    .coord(sample_x), .size(w_eff), .busy(busy_x), .n0(x0), .n1(x1), .frac(fx)
  );

  bwts_wrap #(.MAX_SIDE(MAX_SIDE), .COORD_FRAC_BITS(COORD_FRAC_BITS)) u_wrap_y (
    .clk(clk), .rst(rst), .start(in_xfer && (s_tuser == REQ_SAMPLE)),
    .coord(sample_y), .size(h_eff), .busy(busy_y), .n0(y0), .n1(y1), .frac(fy)
  );

  // texel order: (x0,y0) (x0,y1) (x1,y0) (x1,y1)
  always_comb begin
    case (rd_idx[1:0])
      2'd0:    rd_addr = AW'(32'(y0) * MAX_SIDE + 32'(x0));
      2'd1:    rd_addr = AW'(32'(y1) * MAX_SIDE + 32'(x0));
      2'd2:    rd_addr = AW'(32'(y0) * MAX_SIDE + 32'(x1));
      default: rd_addr = AW'(32'(y1) * MAX_SIDE + 32'(x1));
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) pixel_store[AW'(32'(write_row) * MAX_SIDE + 32'(write_col))] <= write_pixel;
    rd_data <= pixel_store[rd_addr];
  end

  assign en_vert = (state == S_VERT);
  assign en_horz = (state == S_HORZ);

  bwts_blend #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_blend (
    .clk(clk), .en_vert(en_vert), .en_horz(en_horz),
    .c00(tex[0]), .c01(tex[1]), .c10(tex[2]), .c11(tex[3]),
    .fx(fx), .fy(fy), .pixel(blend_pixel)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      rd_idx   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_OUT) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_xfer && (s_tuser == REQ_SAMPLE)) state <= S_WRAP;
        end
        S_WRAP: begin
          rd_idx <= '0;
          if (!busy_x && !busy_y) state <= S_FETCH;
        end
        S_FETCH: begin
          // read data is registered, so it belongs to the previous address
          if (rd_idx != 3'd0) tex[rd_idx[1:0] - 2'd1] <= rd_data;
          rd_idx <= rd_idx + 3'd1;
          if (rd_idx == 3'd4) state <= S_VERT;
        end
        S_VERT: state <= S_HORZ;
        S_HORZ: state <= S_OUT;
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= blend_pixel;
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

`default_nettype wire

@@ dv/bilinear_wrap_texture_sampler_core_tb.sv @@
// ----------------------------------------------------------------------------
// bilinear_wrap_texture_sampler_core_tb
// Fills the pixel store under several image sizes and checks bilinear,
// repeat-wrapped samples against a predictor held in the testbench.
// ----------------------------------------------------------------------------
module bilinear_wrap_texture_sampler_core_tb;
  import bwts_pkg::*;

  localparam int FracBits = 8;
  localparam int Side     = 256;
  localparam int TimeoutCycles = 400000;

  typedef struct packed {
    logic        kind;
    logic [23:0] y;
    logic [23:0] x;
    logic [31:0] pix;
    logic [7:0]  row;
    logic [7:0]  col;
  } req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [InDataW-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [PixelW-1:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [SizeRegW-1:0] cfg_data = '0;

  bilinear_wrap_texture_sampler_core i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // predictor state
  logic [31:0] texels [Side*Side];
  int          img_w = 1;
  int          img_h = 1;

  req_t        pending_reqs[$];
  logic [31:0] expected_pixels[$];
  int          errors = 0;
  int          n_samples = 0;
  int          n_writes = 0;
  int          n_results = 0;
  int          cycles = 0;
  int          hold_off = 0;

  function automatic int clamp_size(int r);
    if (r < 1) return 1;
    if (r > Side) return Side;
    return r;
  endfunction

  // near texel, far texel and weight of the far one
  function automatic void wrap_coord(input logic signed [23:0] c, input int size,
                                     output int n0, output int n1, output int f);
    longint period;
    longint w;
    period = longint'(size) << FracBits;
    w = longint'(c) % period;
    if (w < 0) w += period;
    if (w >= 128) n0 = int'((w - 128) >> FracBits);
    else n0 = size - 1;
    n1 = (n0 < size - 1) ? n0 + 1 : 0;
    f = int'((w + 128) & 255);
  endfunction

  function automatic logic [31:0] blend(logic [23:0] sx, logic [23:0] sy);
    int x0, x1, y0, y1, fx, fy, gx, gy;
    logic [31:0] c00, c01, c10, c11, res;
    longint a, b, c, d, sum, v;
    wrap_coord(sx, img_w, x0, x1, fx);
    wrap_coord(sy, img_h, y0, y1, fy);
    gx = 256 - fx;
    gy = 256 - fy;
    c00 = texels[y0*Side + x0];
    c01 = texels[y1*Side + x0];
    c10 = texels[y0*Side + x1];
    c11 = texels[y1*Side + x1];
    res = '0;
    for (int ch = 0; ch < NumChan; ch++) begin
      a = c00[ch*8 +: 8]; b = c01[ch*8 +: 8];
      c = c10[ch*8 +: 8]; d = c11[ch*8 +: 8];
      sum = (a*gy + b*fy)*gx + (c*gy + d*fy)*fx;
      v = sum >> 16;
      if (v > 255) v = 255;
      res[ch*8 +: 8] = v[7:0];
    end
    return res;
  endfunction

  function automatic void predict(req_t r);
    if (r.kind == REQ_WRITE) begin
      n_writes++;
      if (r.col < img_w && r.row < img_h) begin
        texels[r.row*Side + r.col] = r.pix;
      end
    end else begin
      n_samples++;
      expected_pixels.push_back(blend(r.x, r.y));
    end
  endfunction

  // driver: bursts and gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) predict(pending_reqs.pop_front());
      if (!s_tvalid || s_tready) begin
        if (s_tvalid && s_tready && burst_left > 0) burst_left--;
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (burst_left == 0 && (s_tvalid && s_tready)) begin
          gap_left = $urandom_range(0, 3) == 0 ? $urandom_range(1, 12) : 0;
          burst_left = $urandom_range(1, 10);
          s_tvalid <= 1'b0;
        end else if (pending_reqs.size() > (s_tvalid && s_tready ? 0 : 0)) begin
          if (burst_left == 0) burst_left = $urandom_range(1, 10);
          s_tvalid <= 1'b1;
          s_tdata <= {pending_reqs[0].y, pending_reqs[0].x, pending_reqs[0].pix,
                      pending_reqs[0].row, pending_reqs[0].col};
          s_tuser <= pending_reqs[0].kind;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor with its own stall pattern and an occasional long hold-off
  logic [7:0] stall_lfsr = 8'h5a;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        n_results++;
        if (expected_pixels.size() == 0) begin
          $error("unexpected sampled_pixel %h", m_tdata);
          errors++;
        end else begin
          logic [31:0] exp_pix;
          exp_pix = expected_pixels.pop_front();
          if (m_tdata !== exp_pix) begin
            $error("sampled_pixel expected %h actual %h", exp_pix, m_tdata);
            errors++;
          end
        end
      end
      stall_lfsr <= {stall_lfsr[6:0], stall_lfsr[7] ^ stall_lfsr[5] ^ stall_lfsr[4] ^
                     stall_lfsr[3]};
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        m_tready <= 1'b0;
      end else if (cycles % 5000 == 2500) begin
        hold_off <= 600;
        m_tready <= 1'b0;
      end else if (cycles % 4000 < 1200) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= stall_lfsr[1:0] != 2'b00;
      end
    end
    if (cycles >= TimeoutCycles) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_size(logic [CfgIdxW-1:0] idx, logic [SizeRegW-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_WIDTH) img_w = clamp_size(int'(val));
    else img_h = clamp_size(int'(val));
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || expected_pixels.size() > 0 || s_tvalid)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic req_t mk_write(int col, int row, logic [31:0] pix);
    req_t r;
    r = '0;
    r.kind = REQ_WRITE;
    r.col = col[7:0];
    r.row = row[7:0];
    r.pix = pix;
    return r;
  endfunction

  function automatic req_t mk_sample(logic [23:0] x, logic [23:0] y);
    req_t r;
    r.kind = REQ_SAMPLE;
    r.x = x;
    r.y = y;
    r.col = 8'($urandom);
    r.row = 8'($urandom);
    r.pix = $urandom;
    return r;
  endfunction

  // fill the whole configured image so samples never touch an unwritten texel
  task automatic fill_image(int w, int h);
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++)
        pending_reqs.push_back(mk_write(c, r, $urandom));
  endtask

  task automatic random_phase(int w, int h, int n);
    for (int i = 0; i < n; i++) begin
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
        // writes in and out of range
        pending_reqs.push_back(mk_write($urandom_range(0, 255), $urandom_range(0, 255),
                                        $urandom));
      end else if (pick < 4) begin
        pending_reqs.push_back(mk_write($urandom_range(0, w-1), $urandom_range(0, h-1),
                                        $urandom));
      end else if (pick < 6) begin
        pending_reqs.push_back(mk_sample(24'($urandom), 24'($urandom)));
      end else begin
        pending_reqs.push_back(mk_sample(24'($urandom_range(0, w*256+300) - 150),
                                         24'($urandom_range(0, h*256+300) - 150)));
      end
    end
  endtask

  int sizes_w[5] = '{1, 3, 17, 2, 9};
  int sizes_h[5] = '{1, 4, 5, 13, 3};

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    // directed: default 1x1 image, extreme coordinates
    pending_reqs.push_back(mk_write(0, 0, 32'hffffffff));
    pending_reqs.push_back(mk_write(1, 0, 32'h12345678));  // outside image, ignored
    pending_reqs.push_back(mk_write(0, 255, 32'h0));       // outside image, ignored
    pending_reqs.push_back(mk_sample(24'h000000, 24'h000000));
    pending_reqs.push_back(mk_sample(24'h7fffff, 24'h800000));
    pending_reqs.push_back(mk_sample(24'h800000, 24'h7fffff));
    pending_reqs.push_back(mk_sample(24'hffffff, 24'h000080));
    drain();
    // size registers of zero and above the maximum; samples touch rows 254, 255, 0
    write_size(REG_WIDTH, 9'd0);
    write_size(REG_HEIGHT, 9'h1ff);
    pending_reqs.push_back(mk_write(0, 0, $urandom));
    pending_reqs.push_back(mk_write(0, 254, $urandom));
    pending_reqs.push_back(mk_write(0, 255, $urandom));
    pending_reqs.push_back(mk_sample(24'h000080, 24'hffff7f));
    pending_reqs.push_back(mk_sample(24'h0000ff, 24'h00ff80));
    pending_reqs.push_back(mk_write(0, 255, 32'h00ff00ff));
    pending_reqs.push_back(mk_sample(24'h000000, 24'h000000));
    drain();
    for (int p = 0; p < 5; p++) begin
      write_size(REG_WIDTH, sizes_w[p][8:0]);
      write_size(REG_HEIGHT, sizes_h[p][8:0]);
      fill_image(img_w, img_h);
      random_phase(img_w, img_h, 78);
      drain();
    end
    $display("covered %0d writes and %0d samples, %0d pixels checked", n_writes,
             n_samples, n_results);
    $display("image sizes from 1x1 up to 17 wide and 13 high, plus a clamped 1x256 image");
    if (errors == 0 && expected_pixels.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

@@ files.f @@
src/bwts_pkg.sv
src/bwts_wrap.sv
src/bwts_blend.sv
src/bilinear_wrap_texture_sampler_core.sv
dv/bilinear_wrap_texture_sampler_core_tb.sv
